// ===== hw/rtl/tks_pkg.sv =====
// token sampler package: widths, constants, shared types and the 2^-x root table
// used by every module of the sampler but tks_check; no dependencies
`default_nettype none

package tks_pkg;

	localparam int VOCAB_MAX     = 4096;
	localparam int SHORTLIST_MAX = 256;
	localparam int LOGIT_W       = 24;
	localparam int IDX_W         = 12;
	localparam int CNT_W         = 13;
	localparam int SL_W          = 8;
	localparam int SLC_W         = 9;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [16:0] ONE_Q16   = 17'd65536;
	localparam logic [23:0] LOGIT_MIN = 24'h800000;

	localparam logic [63:0] GOLDEN   = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_C1   = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_C2   = 64'h94D049BB133111EB;
	localparam logic [63:0] SEED_MUL = 64'hD1B54A32D192ED03;
	localparam logic [63:0] XS_MUL   = 64'h2545F4914F6CDD1D;

	typedef enum logic [2:0] {
		REG_TEMP    = 3'd0,
		REG_NUCLEUS = 3'd1,
		REG_LIMIT   = 3'd2,
		REG_SEED_EN = 3'd3,
		REG_SEED    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [LOGIT_W-1:0] logit;
	} slot_t;

	typedef struct packed {
		logic               start;
		logic               use_temp;
		logic [LOGIT_W-1:0] span;
	} exp_req_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] xv;
		r  = 64'd0;
		b  = 64'h4000_0000_0000_0000;
		xv = x;
		for (int s = 0; s < 32; s++) begin
			if (xv >= r + b) begin
				xv = xv - (r + b);
				r  = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] root_at(input int j);
		logic [63:0] r;
		r = isqrt64(64'h8000_0000_0000_0000);
		for (int s = 1; s <= j; s++) begin
			r = isqrt64({r[31:0], 32'd0});
		end
		return r[31:0];
	endfunction

	localparam logic [31:0] ROOTS [16] = '{
		root_at(0),  root_at(1),  root_at(2),  root_at(3),
		root_at(4),  root_at(5),  root_at(6),  root_at(7),
		root_at(8),  root_at(9),  root_at(10), root_at(11),
		root_at(12), root_at(13), root_at(14), root_at(15)
	};

endpackage

`default_nettype wire

// ===== hw/rtl/tks_div.sv =====
// token sampler restoring divider, one quotient bit per cycle
// depends on tks_pkg
`default_nettype none

module tks_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             done,
	output logic [32:0]      quotient
);
	import tks_pkg::*;

	logic [32:0] q_q;
	logic [16:0] r_q;
	logic [15:0] d_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [16:0] r_sh;
	logic        fits;

	assign r_sh = {r_q[15:0], q_q[32]};
	assign fits = r_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			q_q    <= '0;
			r_q    <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				q_q   <= dividend;
				r_q   <= '0;
				d_q   <= divisor;
				cnt_q <= 6'd33;
				run_q <= 1'b1;
			end else if (run_q) begin
				r_q   <= fits ? (r_sh - {1'b0, d_q}) : r_sh;
				q_q   <= {q_q[31:0], fits};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tks_exp.sv =====
// token sampler weight unit: distance times log2(e), optional divide by temperature,
// then 2^-y by sixteen root multiplies and a final shift; depends on tks_pkg, tks_div
`default_nettype none

module tks_exp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tks_pkg::exp_req_t req,
	input  wire logic [15:0]       temp,
	output logic                   done,
	output logic [31:0]            weight
);
	import tks_pkg::*;

	typedef enum logic [4:0] {
		E_IDLE  = 5'b00001,
		E_MUL   = 5'b00010,
		E_DIV   = 5'b00100,
		E_POW   = 5'b01000,
		E_SHIFT = 5'b10000
	} exp_state_t;

	exp_state_t         state_q;
	logic [LOGIT_W-1:0] dist_q;
	logic               use_q;
	logic [40:0]        p_q;
	logic               p_ok_q;
	logic [32:0]        y_q;
	logic [31:0]        v_q;
	logic               one_q;
	logic [3:0]         j_q;
	logic               done_q;
	logic [31:0]        weight_q;
	logic               div_start;
	logic               div_done;
	logic [32:0]        div_q;
	logic [63:0]        vr;
	logic [16:0]        n_c;

	assign vr  = v_q * ROOTS[j_q];
	assign n_c = y_q[32:16];
	assign div_start = (state_q == E_MUL) && p_ok_q && use_q;

	tks_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (p_q[40:8]),
		.divisor  (temp),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			done_q   <= 1'b0;
			p_ok_q   <= 1'b0;
			dist_q   <= '0;
			use_q    <= 1'b0;
			p_q      <= '0;
			y_q      <= '0;
			v_q      <= '0;
			one_q    <= 1'b1;
			j_q      <= '0;
			weight_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				E_IDLE: begin
					if (req.start) begin
						dist_q  <= req.span;
						use_q   <= req.use_temp;
						p_ok_q  <= 1'b0;
						state_q <= E_MUL;
					end
				end
				E_MUL: begin
					if (!p_ok_q) begin
						p_q    <= 41'(dist_q) * 41'(LOG2E_Q16);
						p_ok_q <= 1'b1;
					end else if (use_q) begin
						state_q <= E_DIV;
					end else begin
						y_q     <= {8'd0, p_q[40:16]};
						j_q     <= '0;
						one_q   <= 1'b1;
						state_q <= E_POW;
					end
				end
				E_DIV: begin
					if (div_done) begin
						y_q     <= div_q;
						j_q     <= '0;
						one_q   <= 1'b1;
						state_q <= E_POW;
					end
				end
				E_POW: begin
					if (y_q[4'd15 - j_q]) begin
						if (one_q) begin
							v_q <= ROOTS[j_q];
						end else begin
							v_q <= vr[63:32];
						end
						one_q <= 1'b0;
					end
					if (j_q == 4'd15) begin
						state_q <= E_SHIFT;
					end else begin
						j_q <= j_q + 4'd1;
					end
				end
				E_SHIFT: begin
					if (n_c >= 17'd32) begin
						weight_q <= '0;
					end else if (one_q) begin
						if (n_c == 17'd0) begin
							weight_q <= 32'hFFFF_FFFF;
						end else begin
							weight_q <= 32'(33'h1_0000_0000 >> n_c[4:0]);
						end
					end else begin
						weight_q <= v_q >> n_c[4:0];
					end
					done_q  <= 1'b1;
					state_q <= E_IDLE;
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign weight = weight_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tks_mul.sv =====
// token sampler 64 by 64 multiplier, low 64 bits, three 32 by 32 partial products
// depends on tks_pkg
`default_nettype none

module tks_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      prod
);
	import tks_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_LL   = 4'b0010,
		M_LH   = 4'b0100,
		M_HL   = 4'b1000
	} mul_state_t;

	mul_state_t  state_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic        done_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] pp;

	always_comb begin
		case (state_q)
			M_LH: begin
				op_a = a_q[31:0];
				op_b = b_q[63:32];
			end
			M_HL: begin
				op_a = a_q[63:32];
				op_b = b_q[31:0];
			end
			default: begin
				op_a = a_q[31:0];
				op_b = b_q[31:0];
			end
		endcase
	end

	assign pp = op_a * op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			acc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						a_q     <= a;
						b_q     <= b;
						state_q <= M_LL;
					end
				end
				M_LL: begin
					acc_q   <= pp;
					state_q <= M_LH;
				end
				M_LH: begin
					acc_q   <= acc_q + {pp[31:0], 32'd0};
					state_q <= M_HL;
				end
				M_HL: begin
					acc_q   <= acc_q + {pp[31:0], 32'd0};
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

// ===== hw/rtl/token_sampler_topk_topp.sv =====
// token sampler top level: one logit item per cycle while loading; after the last item
// the block is busy until the done strobe. Greedy scan reads and compares each item.
// Sampling does an exponent pass per item through the shared weight unit, a shortlist
// insert per item, a top-P scan per entry, a weighting per survivor (divider and root
// multiplies), seeding with or without a set seed, the draw setup, then the draw steps.
// Async reset clears control, not the stores. No receiver stall.
`default_nettype none

module token_sampler_topk_topp (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [23:0] logit,
	input  wire logic        is_last,
	input  wire logic [30:0] position,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [63:0] wr_data,
	output logic             done,
	output logic [11:0]      token,
	output logic             status
);
	import tks_pkg::*;

	typedef enum logic [31:0] {
		ST_IDLE   = 32'd1 << 0,
		ST_CHECK  = 32'd1 << 1,
		ST_G_RD   = 32'd1 << 2,
		ST_G_CMP  = 32'd1 << 3,
		ST_E_RD   = 32'd1 << 4,
		ST_E_GO   = 32'd1 << 5,
		ST_E_WAIT = 32'd1 << 6,
		ST_S_RD   = 32'd1 << 7,
		ST_S_LD   = 32'd1 << 8,
		ST_S_CW   = 32'd1 << 9,
		ST_S_CHK  = 32'd1 << 10,
		ST_S_MW   = 32'd1 << 11,
		ST_S_CMP  = 32'd1 << 12,
		ST_S_PUT  = 32'd1 << 13,
		ST_P_TH   = 32'd1 << 14,
		ST_P_RD   = 32'd1 << 15,
		ST_P_GO   = 32'd1 << 16,
		ST_P_WAIT = 32'd1 << 17,
		ST_CUT    = 32'd1 << 18,
		ST_W_RD   = 32'd1 << 19,
		ST_W_GO   = 32'd1 << 20,
		ST_W_WAIT = 32'd1 << 21,
		ST_R_SEED = 32'd1 << 22,
		ST_R_POSW = 32'd1 << 23,
		ST_R_MIX  = 32'd1 << 24,
		ST_R_M1W  = 32'd1 << 25,
		ST_R_M2W  = 32'd1 << 26,
		ST_R_XS   = 32'd1 << 27,
		ST_R_XSW  = 32'd1 << 28,
		ST_D_PRE  = 32'd1 << 29,
		ST_D_RD   = 32'd1 << 30,
		ST_D_CMP  = 32'd1 << 31
	} state_t;

	// configuration
	logic [15:0] temp_q;
	logic [16:0] nm_q;
	logic [8:0]  lim_q;
	logic        sen_q;
	logic [63:0] seed_q;

	// stores
	logic [LOGIT_W-1:0] logit_mem  [VOCAB_MAX];
	slot_t              slot_mem   [SHORTLIST_MAX];
	logic [31:0]        weight_mem [SHORTLIST_MAX];
	logic [LOGIT_W-1:0] lmem_q;
	slot_t              smem_q;
	logic [31:0]        wmem_q;
	logic [IDX_W-1:0]   la_q;
	logic [SL_W-1:0]    sa_q;
	logic               swe_q;
	logic [SL_W-1:0]    swa_q;
	slot_t              swd_q;
	logic               wwe_q;
	logic [SL_W-1:0]    wwa_q;
	logic [31:0]        wwd_q;

	// sequencer
	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LOGIT_W-1:0] rmax_q;
	logic [30:0]        pos_q;
	logic [CNT_W-1:0]   i_q;
	logic [SLC_W-1:0]   want_q;
	logic [SLC_W-1:0]   scnt_q;
	logic [SLC_W-1:0]   k_q;
	logic [SLC_W-1:0]   cut_q;
	logic [LOGIT_W-1:0] v_q;
	logic [47:0]        etot_q;
	logic [47:0]        thr_q;
	logic [47:0]        acc_q;
	logic [47:0]        wsum_q;
	logic [63:0]        x_q;
	logic [71:0]        uw_q;
	logic [11:0]        token_q;
	logic               status_q;
	logic               done_q;
	exp_req_t           ereq_q;
	logic               mstart_q;
	logic [63:0]        ma_q;
	logic [63:0]        mb_q;

	// unit outputs
	logic        e_done;
	logic [31:0] e_weight;
	logic        m_done;
	logic [63:0] m_prod;

	// helpers
	logic             accept;
	logic [24:0]      dl;
	logic [24:0]      ds;
	logic             invalid_c;
	logic [SLC_W-1:0] kw_c;
	logic [SLC_W-1:0] want_c;
	logic [SLC_W-1:0] scnt_inc;
	logic [64:0]      tp_c;
	logic [SLC_W-1:0] cut_c;
	logic [47:0]      acc_e;
	logic [47:0]      acc_d;
	logic [63:0]      mix_t;
	logic [63:0]      z_c;
	logic [63:0]      xs1;
	logic [63:0]      xs2;
	logic [63:0]      xs3;
	logic             last_i;
	logic             last_s;
	logic             last_c;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign dl = {rmax_q[23], rmax_q} - {lmem_q[23], lmem_q};
	assign ds = {rmax_q[23], rmax_q} - {smem_q.logit[23], smem_q.logit};

	assign invalid_c = (nm_q == 17'd0) || (nm_q > ONE_Q16) ||
		(lim_q > SLC_W'(SHORTLIST_MAX)) ||
		((temp_q != 16'd0) && (nm_q < ONE_Q16) && (lim_q == 9'd0));
	assign kw_c     = (lim_q != 9'd0) ? lim_q : SLC_W'(SHORTLIST_MAX);
	assign want_c   = ({4'd0, kw_c} > cnt_q) ? cnt_q[SLC_W-1:0] : kw_c;
	assign scnt_inc = (scnt_q < want_q) ? (scnt_q + 9'd1) : scnt_q;
	assign tp_c     = 65'(etot_q) * 65'(nm_q[15:0]) + 65'h0_FFFF;
	assign cut_c    = ((lim_q != 9'd0) && (cut_q > lim_q)) ? lim_q :
		((cut_q == 9'd0) ? 9'd1 : cut_q);
	assign acc_e    = acc_q + {16'd0, e_weight};
	assign acc_d    = acc_q + {16'd0, wmem_q};
	assign mix_t    = x_q + GOLDEN;
	assign z_c      = m_prod ^ (m_prod >> 31);
	assign xs1      = x_q ^ (x_q >> 12);
	assign xs2      = xs1 ^ (xs1 << 25);
	assign xs3      = xs2 ^ (xs2 >> 27);
	assign last_i   = (i_q + 13'd1) == cnt_q;
	assign last_s   = (i_q + 13'd1) == {4'd0, scnt_q};
	assign last_c   = (i_q + 13'd1) == {4'd0, cut_q};

	tks_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ereq_q),
		.temp   (temp_q),
		.done   (e_done),
		.weight (e_weight)
	);

	tks_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart_q),
		.a      (ma_q),
		.b      (mb_q),
		.done   (m_done),
		.prod   (m_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= 16'd256;
			nm_q   <= ONE_Q16;
			lim_q  <= '0;
			sen_q  <= 1'b0;
			seed_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_TEMP:    temp_q <= wr_data[15:0];
				REG_NUCLEUS: nm_q   <= wr_data[16:0];
				REG_LIMIT:   lim_q  <= wr_data[8:0];
				REG_SEED_EN: sen_q  <= wr_data[0];
				REG_SEED:    seed_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cnt_q < CNT_W'(VOCAB_MAX))) begin
			logit_mem[cnt_q[IDX_W-1:0]] <= logit;
		end
		lmem_q <= logit_mem[la_q];
	end

	always_ff @(posedge clk) begin
		if (swe_q) begin
			slot_mem[swa_q] <= swd_q;
		end
		if (wwe_q) begin
			weight_mem[wwa_q] <= wwd_q;
		end
		smem_q <= slot_mem[sa_q];
		wmem_q <= weight_mem[sa_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			rmax_q   <= LOGIT_MIN;
			pos_q    <= '0;
			i_q      <= '0;
			want_q   <= '0;
			scnt_q   <= '0;
			k_q      <= '0;
			cut_q    <= '0;
			v_q      <= '0;
			etot_q   <= '0;
			thr_q    <= '0;
			acc_q    <= '0;
			wsum_q   <= '0;
			x_q      <= '0;
			uw_q     <= '0;
			token_q  <= '0;
			status_q <= 1'b0;
			done_q   <= 1'b0;
			ereq_q   <= '0;
			mstart_q <= 1'b0;
			ma_q     <= '0;
			mb_q     <= '0;
			la_q     <= '0;
			sa_q     <= '0;
			swe_q    <= 1'b0;
			swa_q    <= '0;
			swd_q    <= '0;
			wwe_q    <= 1'b0;
			wwa_q    <= '0;
			wwd_q    <= '0;
		end else begin
			done_q       <= 1'b0;
			ereq_q.start <= 1'b0;
			mstart_q     <= 1'b0;
			swe_q        <= 1'b0;
			wwe_q        <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cnt_q < CNT_W'(VOCAB_MAX)) begin
							cnt_q <= cnt_q + 13'd1;
							if ($signed(logit) > $signed(rmax_q)) begin
								rmax_q <= logit;
							end
						end
						if (is_last) begin
							pos_q   <= position;
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					i_q  <= '0;
					la_q <= '0;
					if (invalid_c) begin
						token_q  <= '0;
						status_q <= 1'b1;
						done_q   <= 1'b1;
						cnt_q    <= '0;
						rmax_q   <= LOGIT_MIN;
						state_q  <= ST_IDLE;
					end else if (temp_q == 16'd0) begin
						state_q <= ST_G_RD;
					end else begin
						etot_q  <= '0;
						state_q <= ST_E_RD;
					end
				end
				ST_G_RD: begin
					state_q <= ST_G_CMP;
				end
				ST_G_CMP: begin
					if ((lmem_q == rmax_q) || last_i) begin
						token_q  <= (lmem_q == rmax_q) ? i_q[IDX_W-1:0] : 12'd0;
						status_q <= 1'b0;
						done_q   <= 1'b1;
						cnt_q    <= '0;
						rmax_q   <= LOGIT_MIN;
						state_q  <= ST_IDLE;
					end else begin
						i_q     <= i_q + 13'd1;
						la_q    <= i_q[IDX_W-1:0] + 12'd1;
						state_q <= ST_G_RD;
					end
				end
				ST_E_RD: begin
					state_q <= ST_E_GO;
				end
				ST_E_GO: begin
					ereq_q.start    <= 1'b1;
					ereq_q.use_temp <= 1'b0;
					ereq_q.span     <= dl[23:0];
					state_q         <= ST_E_WAIT;
				end
				ST_E_WAIT: begin
					if (e_done) begin
						etot_q <= etot_q + {16'd0, e_weight};
						if (last_i) begin
							i_q     <= '0;
							la_q    <= '0;
							scnt_q  <= '0;
							want_q  <= want_c;
							state_q <= ST_S_RD;
						end else begin
							i_q     <= i_q + 13'd1;
							la_q    <= i_q[IDX_W-1:0] + 12'd1;
							state_q <= ST_E_RD;
						end
					end
				end
				ST_S_RD: begin
					state_q <= ST_S_LD;
				end
				ST_S_LD: begin
					v_q <= lmem_q;
					if (scnt_q == want_q) begin
						k_q     <= want_q - 9'd1;
						sa_q    <= SL_W'(want_q - 9'd1);
						state_q <= ST_S_CW;
					end else begin
						k_q <= scnt_q;
						if (scnt_q == 9'd0) begin
							state_q <= ST_S_PUT;
						end else begin
							sa_q    <= SL_W'(scnt_q - 9'd1);
							state_q <= ST_S_MW;
						end
					end
				end
				ST_S_CW: begin
					state_q <= ST_S_CHK;
				end
				ST_S_CHK: begin
					if ($signed(v_q) > $signed(smem_q.logit)) begin
						if (k_q == 9'd0) begin
							state_q <= ST_S_PUT;
						end else begin
							sa_q    <= SL_W'(k_q - 9'd1);
							state_q <= ST_S_MW;
						end
					end else if (last_i) begin
						if (nm_q < ONE_Q16) begin
							state_q <= ST_P_TH;
						end else begin
							cut_q   <= scnt_q;
							state_q <= ST_CUT;
						end
					end else begin
						i_q     <= i_q + 13'd1;
						la_q    <= i_q[IDX_W-1:0] + 12'd1;
						state_q <= ST_S_RD;
					end
				end
				ST_S_MW: begin
					state_q <= ST_S_CMP;
				end
				ST_S_CMP: begin
					if ($signed(v_q) > $signed(smem_q.logit)) begin
						swe_q <= 1'b1;
						swa_q <= k_q[SL_W-1:0];
						swd_q <= smem_q;
						k_q   <= k_q - 9'd1;
						if (k_q == 9'd1) begin
							state_q <= ST_S_PUT;
						end else begin
							sa_q    <= SL_W'(k_q - 9'd2);
							state_q <= ST_S_MW;
						end
					end else begin
						state_q <= ST_S_PUT;
					end
				end
				ST_S_PUT: begin
					swe_q       <= 1'b1;
					swa_q       <= k_q[SL_W-1:0];
					swd_q.idx   <= i_q[IDX_W-1:0];
					swd_q.logit <= v_q;
					scnt_q      <= scnt_inc;
					if (last_i) begin
						if (nm_q < ONE_Q16) begin
							state_q <= ST_P_TH;
						end else begin
							cut_q   <= scnt_inc;
							state_q <= ST_CUT;
						end
					end else begin
						i_q     <= i_q + 13'd1;
						la_q    <= i_q[IDX_W-1:0] + 12'd1;
						state_q <= ST_S_RD;
					end
				end
				ST_P_TH: begin
					thr_q   <= tp_c[63:16];
					acc_q   <= '0;
					i_q     <= '0;
					sa_q    <= '0;
					state_q <= ST_P_RD;
				end
				ST_P_RD: begin
					state_q <= ST_P_GO;
				end
				ST_P_GO: begin
					ereq_q.start    <= 1'b1;
					ereq_q.use_temp <= 1'b0;
					ereq_q.span     <= ds[23:0];
					state_q         <= ST_P_WAIT;
				end
				ST_P_WAIT: begin
					if (e_done) begin
						acc_q <= acc_e;
						if (acc_e >= thr_q) begin
							cut_q   <= SLC_W'(i_q + 13'd1);
							state_q <= ST_CUT;
						end else if (last_s) begin
							cut_q   <= scnt_q;
							state_q <= ST_CUT;
						end else begin
							i_q     <= i_q + 13'd1;
							sa_q    <= i_q[SL_W-1:0] + 8'd1;
							state_q <= ST_P_RD;
						end
					end
				end
				ST_CUT: begin
					cut_q   <= cut_c;
					i_q     <= '0;
					sa_q    <= '0;
					wsum_q  <= '0;
					state_q <= ST_W_RD;
				end
				ST_W_RD: begin
					state_q <= ST_W_GO;
				end
				ST_W_GO: begin
					ereq_q.start    <= 1'b1;
					ereq_q.use_temp <= 1'b1;
					ereq_q.span     <= ds[23:0];
					state_q         <= ST_W_WAIT;
				end
				ST_W_WAIT: begin
					if (e_done) begin
						wwe_q  <= 1'b1;
						wwa_q  <= i_q[SL_W-1:0];
						wwd_q  <= e_weight;
						wsum_q <= wsum_q + {16'd0, e_weight};
						if (last_c) begin
							state_q <= ST_R_SEED;
						end else begin
							i_q     <= i_q + 13'd1;
							sa_q    <= i_q[SL_W-1:0] + 8'd1;
							state_q <= ST_W_RD;
						end
					end
				end
				ST_R_SEED: begin
					if (sen_q) begin
						x_q     <= seed_q + {33'd0, pos_q};
						state_q <= ST_R_MIX;
					end else begin
						ma_q     <= {33'd0, pos_q};
						mb_q     <= SEED_MUL;
						mstart_q <= 1'b1;
						state_q  <= ST_R_POSW;
					end
				end
				ST_R_POSW: begin
					if (m_done) begin
						x_q     <= GOLDEN ^ m_prod;
						state_q <= ST_R_MIX;
					end
				end
				ST_R_MIX: begin
					ma_q     <= mix_t ^ (mix_t >> 30);
					mb_q     <= MIX_C1;
					mstart_q <= 1'b1;
					state_q  <= ST_R_M1W;
				end
				ST_R_M1W: begin
					if (m_done) begin
						ma_q     <= m_prod ^ (m_prod >> 27);
						mb_q     <= MIX_C2;
						mstart_q <= 1'b1;
						state_q  <= ST_R_M2W;
					end
				end
				ST_R_M2W: begin
					if (m_done) begin
						x_q     <= (z_c == 64'd0) ? GOLDEN : z_c;
						state_q <= ST_R_XS;
					end
				end
				ST_R_XS: begin
					ma_q     <= xs3;
					mb_q     <= XS_MUL;
					mstart_q <= 1'b1;
					state_q  <= ST_R_XSW;
				end
				ST_R_XSW: begin
					if (m_done) begin
						// uniform times weight sum stays below 2^64
						ma_q     <= {40'd0, m_prod[63:40]};
						mb_q     <= {16'd0, wsum_q};
						mstart_q <= 1'b1;
						state_q  <= ST_D_PRE;
					end
				end
				ST_D_PRE: begin
					if (m_done) begin
						uw_q    <= {8'd0, m_prod};
						i_q     <= '0;
						sa_q    <= '0;
						acc_q   <= '0;
						state_q <= ST_D_RD;
					end
				end
				ST_D_RD: begin
					state_q <= ST_D_CMP;
				end
				ST_D_CMP: begin
					if (({acc_d, 24'd0} >= uw_q) || last_c) begin
						token_q  <= smem_q.idx;
						status_q <= 1'b0;
						done_q   <= 1'b1;
						cnt_q    <= '0;
						rmax_q   <= LOGIT_MIN;
						state_q  <= ST_IDLE;
					end else begin
						acc_q   <= acc_d;
						i_q     <= i_q + 13'd1;
						sa_q    <= i_q[SL_W-1:0] + 8'd1;
						state_q <= ST_D_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign token  = token_q;
	assign status = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tks_check.sv =====
// token sampler port checker and its bind to the top level
// depends on token_sampler_topk_topp
`default_nettype none

module tks_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        is_last,
	input wire logic        done,
	input wire logic [11:0] token,
	input wire logic        status
);

	// a result only closes a busy stretch
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without prior busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !is_last) |=> !busy)
		else $error("non-final item made block busy");

	a_last_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && is_last) |=> busy)
		else $error("final item did not start processing");

	a_bad_token_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (token == 12'd0))
		else $error("invalid settings result with nonzero token");

endmodule

bind token_sampler_topk_topp tks_check u_tks_check (.*);

`default_nettype wire

// ===== test/tb.sv =====
// testbench for token_sampler_topk_topp: directed and random logit vectors under changing
// register settings, checked against a built-in sampler prediction
// depends on tks_pkg and the token_sampler_topk_topp rtl
`default_nettype none

module tb;
	import tks_pkg::*;

	typedef enum int {OP_ITEM, OP_WRITE, OP_DRAIN} op_kind_t;
	typedef struct {
		op_kind_t    kind;
		logic [23:0] lg;
		logic        last;
		logic [30:0] pos;
		logic [2:0]  idx;
		logic [63:0] data;
	} op_t;
	typedef struct {
		logic [11:0] tok;
		logic        st;
	} pick_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [23:0] logit = '0;
	logic        is_last = 1'b0;
	logic [30:0] position = '0;
	logic        wr_en = 1'b0;
	logic [2:0]  wr_index = '0;
	logic [63:0] wr_data = '0;
	logic        busy, done, status;
	logic [11:0] token;

	op_t   pending[$];
	pick_t picks_due[$];
	int    errors = 0;
	logic  took = 1'b0;
	int    gap = 0;
	int    settle = 0;
	bit    quiet = 0;

	// shadow settings and vector state
	int unsigned     s_temp = 256, s_mass = 65536, s_limit = 0, s_seed_en = 0;
	longint unsigned s_seed = 0;
	int              vec[$];
	int              vmax = -8388608;
	longint unsigned roots[16];

	token_sampler_topk_topp i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .logit(logit),
		.is_last(is_last), .position(position), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .done(done), .token(token), .status(status)
	);

	always #6 clk = ~clk;

	function automatic longint unsigned sqrt_floor(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned pow2_neg(longint unsigned y);
		longint unsigned n, f, v;
		n = y >> 16;
		f = y & 64'hFFFF;
		v = 64'd1 << 32;
		if (n >= 32) return 0;
		for (int j = 0; j < 16; j++)
			if ((f >> (15 - j)) & 1) v = (v * roots[j]) >> 32;
		v >>= n;
		return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
	endfunction

	function automatic longint unsigned weight(int lg, int unsigned t);
		longint unsigned d;
		d = longint'(vmax) - longint'(lg);
		if (t == 0) t = 1;
		return pow2_neg((d * 94548) / (longint'(t) * 256));
	endfunction

	function automatic longint unsigned mix64(longint unsigned x);
		x += GOLDEN;
		x = (x ^ (x >> 30)) * MIX_C1;
		x = (x ^ (x >> 27)) * MIX_C2;
		return x ^ (x >> 31);
	endfunction

	function automatic int predict_pick(longint unsigned pos);
		int unsigned n, want, cnt, cut, j, k;
		int sl[256];
		longint unsigned wts[256];
		longint unsigned total, acc, thresh, lo, wsum, base, rs, u;
		n = vec.size();
		total = 0;
		foreach (vec[i]) total += weight(vec[i], 256);
		want = (s_limit > 0) ? s_limit : 256;
		if (want > 256) want = 256;
		if (want > n) want = n;
		cnt = 0;
		for (int unsigned i = 0; i < n; i++) begin
			j = 0;
			while (j < cnt && vec[i] <= vec[sl[j]]) j++;
			if (j < want) begin
				k = (cnt < want) ? cnt : want - 1;
				while (k > j) begin
					sl[k] = sl[k-1];
					k--;
				end
				sl[j] = i;
				if (cnt < want) cnt++;
			end
		end
		cut = cnt;
		if (s_mass < 65536) begin
			lo = (total & 64'hFFFF) * s_mass;
			thresh = (total >> 16) * s_mass + (lo >> 16) + (((lo & 64'hFFFF) != 0) ? 1 : 0);
			acc = 0;
			for (int unsigned i = 0; i < cnt; i++) begin
				acc += weight(vec[sl[i]], 256);
				if (acc >= thresh) begin
					cut = i + 1;
					break;
				end
			end
		end
		if (s_limit > 0 && cut > s_limit) cut = s_limit;
		if (cut < 1) cut = 1;
		wsum = 0;
		for (int unsigned i = 0; i < cut; i++) begin
			wts[i] = weight(vec[sl[i]], s_temp);
			wsum += wts[i];
		end
		base = s_seed_en ? s_seed + pos : (GOLDEN ^ (pos * SEED_MUL));
		rs = mix64(base);
		if (rs == 0) rs = GOLDEN;
		rs ^= rs >> 12;
		rs ^= rs << 25;
		rs ^= rs >> 27;
		u = ((rs * XS_MUL) >> 40) & 64'hFFFFFF;
		acc = 0;
		for (int unsigned i = 0; i < cut; i++) begin
			acc += wts[i];
			if ((acc << 24) >= u * wsum) return sl[i];
		end
		return sl[cut-1];
	endfunction

	task automatic take_logit(logic [23:0] lg, logic last, logic [30:0] pos);
		pick_t p;
		int v;
		v = $signed(lg);
		if (vec.size() < VOCAB_MAX) begin
			vec.push_back(v);
			if (v > vmax) vmax = v;
		end
		if (last) begin
			p.tok = '0;
			p.st = 1'b0;
			if (s_mass == 0 || s_mass > 65536 || s_limit > 256 ||
			    (s_temp > 0 && s_mass < 65536 && s_limit == 0)) begin
				p.st = 1'b1;
			end else if (s_temp == 0) begin
				foreach (vec[i])
					if (vec[i] == vmax) begin
						p.tok = 12'(i);
						break;
					end
			end else begin
				p.tok = 12'(predict_pick(pos));
			end
			picks_due.push_back(p);
			vec.delete();
			vmax = -8388608;
		end
	endtask

	task automatic take_write(logic [2:0] idx, logic [63:0] d);
		case (idx)
			REG_TEMP:    s_temp = 32'(d[15:0]);
			REG_NUCLEUS: s_mass = 32'(d[16:0]);
			REG_LIMIT:   s_limit = 32'(d[8:0]);
			REG_SEED_EN: s_seed_en = 32'(d[0]);
			REG_SEED:    s_seed = d;
			default: ;
		endcase
	endtask

	// monitor: results first, then accepted item and register write
	always @(posedge clk) begin
		pick_t p;
		took <= start && !busy;
		if (arst_n) begin
			if (done) begin
				if (picks_due.size() == 0) begin
					$display("%0t: result with nothing expected: token %0d status %0d",
						$time, token, status);
					errors++;
				end else begin
					p = picks_due.pop_front();
					if (p.tok !== token)
						begin
						$display("%0t: token expected %0d actual %0d", $time, p.tok, token);
						errors++;
					end
					if (p.st !== status) begin
						$display("%0t: status expected %0d actual %0d", $time, p.st, status);
						errors++;
					end
				end
			end
			if (start && !busy) take_logit(logit, is_last, position);
			if (wr_en) take_write(wr_index, wr_data);
		end
	end

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver
	always @(negedge clk) begin
		logic n_start, n_wr;
		op_t o;
		n_start = 1'b0;
		n_wr = 1'b0;
		if (arst_n) begin
			if (start && !took) begin
				n_start = 1'b1;
			end else if (gap > 0) begin
				gap--;
			end else if (pending.size() > 0) begin
				o = pending[0];
				case (o.kind)
					OP_ITEM: begin
						n_start = 1'b1;
						logit <= o.lg;
						is_last <= o.last;
						position <= o.pos;
						void'(pending.pop_front());
						gap = draw_gap();
					end
					OP_WRITE: begin
						n_wr = 1'b1;
						wr_index <= o.idx;
						wr_data <= o.data;
						void'(pending.pop_front());
					end
					default: begin
						if (picks_due.size() != 0 || busy || start) begin
							settle = 0;
						end else if (settle < 30) begin
							settle++;
						end else begin
							settle = 0;
							quiet = ($urandom_range(0, 3) == 0);
							void'(pending.pop_front());
						end
					end
				endcase
			end
		end
		start <= n_start;
		wr_en <= n_wr;
	end

	task automatic add_item(logic [23:0] lg, logic last, logic [30:0] pos);
		op_t o;
		o.kind = OP_ITEM;
		o.lg = lg;
		o.last = last;
		o.pos = pos;
		pending.push_back(o);
	endtask

	task automatic add_write(logic [2:0] idx, logic [63:0] d);
		op_t o;
		o.kind = OP_WRITE;
		o.idx = idx;
		o.data = d;
		pending.push_back(o);
	endtask

	task automatic add_drain();
		op_t o;
		o.kind = OP_DRAIN;
		pending.push_back(o);
	endtask

	task automatic add_settings(int unsigned t, int unsigned m, int unsigned k, bit se,
		longint unsigned sd);
		add_drain();
		add_write(REG_TEMP, t);
		add_write(REG_NUCLEUS, m);
		add_write(REG_LIMIT, k);
		add_write(REG_SEED_EN, se);
		add_write(REG_SEED, sd);
	endtask

	function automatic logic [30:0] rand_pos();
		return {$urandom, $urandom} >> 33;
	endfunction

	function automatic logic [23:0] rand_logit(int mode, int centre);
		if (mode == 0) return $urandom;
		return 24'(centre + $urandom_range(0, (mode == 1) ? 3000 : 200000));
	endfunction

	initial begin
		int len, mode, centre, sent, r;
		int unsigned t, m, k;
		roots[0] = sqrt_floor(64'd1 << 63);
		for (int j = 1; j < 16; j++) roots[j] = sqrt_floor(roots[j-1] << 32);

		// directed: extremes, greedy ties, single item, invalid settings
		add_item(24'h7FFFFF, 1'b0, '0);
		add_item(24'h800000, 1'b0, '0);
		add_item(24'h7FFFFF, 1'b1, 31'h7FFFFFFF);
		add_item(24'h123456, 1'b1, 31'h0);
		add_settings(0, 65536, 0, 0, 0);
		add_item(24'h800000, 1'b0, '0);
		add_item(24'h000010, 1'b0, '0);
		add_item(24'h000010, 1'b1, '0);
		add_item(24'h800000, 1'b1, '0);
		add_settings(256, 1000, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(24'h000000, 1'b1, 31'h55555555);
		add_drain();
		add_write(REG_TEMP, 0);
		add_write(REG_NUCLEUS, 0);
		add_item(24'h000100, 1'b1, '0);
		add_settings(1, 131071, 1, 1, 0);
		add_item(24'h000100, 1'b1, '0);
		add_settings(65535, 65536, 511, 0, 0);
		add_item(24'h000100, 1'b1, '0);
		add_settings(65535, 1, 256, 1, 64'h0123_4567_89AB_CDEF);
		add_item(24'h7FFFFF, 1'b0, 31'h2AAAAAAA);
		add_item(24'h7FFFF0, 1'b0, 31'h2AAAAAAA);
		add_item(24'h800000, 1'b1, 31'h2AAAAAAA);
		add_item(24'h000000, 1'b0, '0);
		add_item(24'hFFFFFF, 1'b1, '0);
		// unknown register indexes are ignored
		add_drain();
		for (int i = 1; i <= 3; i++) add_write(reg_idx_t'(3'(REG_SEED) + 3'(i)), '1);

		sent = 0;
		while (sent < 1680) begin
			r = $urandom_range(0, 99);
			t = (r < 15) ? 0 : (r < 25) ? 1 : (r < 35) ? 65535 : (r < 50) ? 256
				: $urandom_range(1, 65535);
			r = $urandom_range(0, 99);
			m = (r < 40) ? 65536 : (r < 50) ? 1 : (r < 53) ? 0 : (r < 56)
				? $urandom_range(65537, 131071) : $urandom_range(1, 65535);
			r = $urandom_range(0, 99);
			k = (r < 10) ? 256 : (r < 15) ? 1 : (r < 18) ? $urandom_range(257, 511)
				: $urandom_range(1, 16);
			if (m == 65536 && $urandom_range(0, 3) == 0) k = 0;
			if (m < 65536 && m > 0 && $urandom_range(0, 19) == 0) k = 0;
			add_settings(t, m, k, $urandom_range(0, 1), {$urandom, $urandom});
			for (int v = 0; v < 5; v++) begin
				len = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 300)
					: $urandom_range(1, 12);
				mode = $urandom_range(0, 2);
				centre = $signed(24'($urandom));
				for (int i = 0; i < len; i++)
					add_item(rand_logit(mode, centre), i == len - 1, rand_pos());
				sent += len;
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (pending.size() == 0 && !start && picks_due.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && picks_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#(12 * 8000000);
		$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== token_sampler_topk_topp.f =====
hw/rtl/tks_pkg.sv
hw/rtl/tks_div.sv
hw/rtl/tks_exp.sv
hw/rtl/tks_mul.sv
hw/rtl/token_sampler_topk_topp.sv
hw/rtl/tks_check.sv
test/tb.sv
